@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the contact table rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CRT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `CRT_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define CRT_ASSERT(lbl, clk, rstn, prop, msg)
`define CRT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ hw/rtl/crt_pkg.sv @@
// constants, codes and chain types for the contact reference count table
// no dependencies; used by crt_cell and contact_refcount_table
package crt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ID_BITS       = 16;
  localparam int COUNT_BITS    = 8;

  // ids on the ports are 16 bits wide; compares use the low ID_BITS
  localparam int ID_W = (ID_BITS > 16) ? 16 : ID_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // register index on the apb port
  localparam int REG_OWN_BODY_ID = 0;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BEGAN = 2'd1,
    EV_ENDED = 2'd2,
    EV_FULL  = 2'd3
  } event_e;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_END   = 1'b1
  } op_e;

  // notice travelling down the row of cells
  typedef struct packed {
    logic            vld;
    logic            act;
    op_e             op;
    logic [ID_W-1:0] id;
    logic            hit;
    logic            claimed;
    logic            erased;
  } tok_t;

  // broadcast from the end of the row
  typedef struct packed {
    logic done;
    logic commit;
  } cmt_t;

endpackage

@@ hw/rtl/crt_cell.sv @@
// one table slot of the contact table: valid mark, partner id and pair count
// uses crt_pkg and assert_macros.svh
`include "assert_macros.svh"

module crt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  crt_pkg::tok_t tok_i,
  input  crt_pkg::cmt_t cmt_i,
  output crt_pkg::tok_t tok_o
);

  logic                          valid_q, valid_d;
  logic                          pend_q, pend_d;
  logic [crt_pkg::ID_W-1:0]       id_q, id_d;
  logic [crt_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;
  crt_pkg::tok_t                 tok_q, tok_d;
  logic                          hit_here;
  logic                          claim_here;

  assign hit_here = tok_i.vld && tok_i.act && valid_q && !tok_i.hit && (id_q == tok_i.id);
  assign claim_here = tok_i.vld && tok_i.act && !valid_q && !pend_q &&
                      (tok_i.op == crt_pkg::OP_BEGIN) && !tok_i.claimed;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    id_d    = id_q;
    cnt_d   = cnt_q;
    tok_d   = tok_i;
    // end of a pass: a claimed free slot is taken or released
    if (cmt_i.done) begin
      pend_d = 1'b0;
      if (cmt_i.commit && pend_q) begin
        valid_d = 1'b1;
        cnt_d   = crt_pkg::CNT_ONE;
      end
    end
    if (hit_here) begin
      tok_d.hit = 1'b1;
      if (tok_i.op == crt_pkg::OP_BEGIN) begin
        if (cnt_q != crt_pkg::CNT_MAX) begin
          cnt_d = cnt_q + crt_pkg::CNT_ONE;
        end
      end else if (cnt_q > crt_pkg::CNT_ONE) begin
        cnt_d = cnt_q - crt_pkg::CNT_ONE;
      end else begin
        valid_d      = 1'b0;
        tok_d.erased = 1'b1;
      end
    end else if (claim_here) begin
      // hold the slot until the pass shows the partner is not stored further on
      pend_d        = 1'b1;
      id_d          = tok_i.id;
      tok_d.claimed = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    cnt_q <= cnt_d;
  end

  assign tok_o = tok_q;

  `CRT_ASSERT_NEVER(a_pend_on_valid, clk_i, rst_ni, valid_q && pend_q,
                    "slot claimed while holding a partner")
  `CRT_ASSERT(a_cnt_nonzero, clk_i, rst_ni, valid_q |-> (cnt_q != '0),
              "stored partner with zero count")
  `CRT_ASSERT_NEVER(a_erase_without_hit, clk_i, rst_ni, tok_q.erased && !tok_q.hit,
                    "notice marks an erase but found no partner")

endmodule

@@ hw/rtl/contact_refcount_table.sv @@
// top level of the contact reference count table: row of crt_cell slots,
// notice intake, result register and apb register port; uses crt_pkg, crt_cell
//
//  channel   ports                                       transfer
//  notice    start, busy, operation_i, body_a_i/_b_i     start && !busy
//  result    res_valid_o, event_res_o, partner_id_o,     res_valid_o, one cycle
//            pair_count_o
//  config    psel, penable, pwrite, paddr, pwdata,       psel && penable && pwrite
//            prdata, pready
//
// a notice walks the row one slot per cycle, and the result register after the
// last slot shows its outcome.
// busy stays high until the cycle that shows the result, so one notice is in
// the row at a time and a new one can be taken from that cycle on.
// the last cycle of the walk commits a new entry into the slot it claimed.
// reset clears all valid marks at once; the result side cannot stall.
`include "assert_macros.svh"

module contact_refcount_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [0:0]  operation_i,
  input  logic [15:0] body_a_i,
  input  logic [15:0] body_b_i,
  output logic        res_valid_o,
  output logic [1:0]  event_res_o,
  output logic [15:0] partner_id_o,
  output logic [7:0]  pair_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] AddrOwnId = 3'(4 * crt_pkg::REG_OWN_BODY_ID);

  logic [15:0]              own_q;
  logic                     busy_q;
  logic                     accept;
  logic [crt_pkg::ID_W-1:0] a_id, b_id, own_id;
  crt_pkg::tok_t            tok_w [crt_pkg::TABLE_ENTRIES+1];
  crt_pkg::tok_t            last;
  crt_pkg::cmt_t            cmt;
  crt_pkg::event_e          ev;
  logic                     res_valid_q;
  crt_pkg::event_e          ev_q;
  logic [15:0]              pid_q;
  logic [7:0]               cnt_q;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == AddrOwnId) ? 32'(own_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == AddrOwnId)) begin
      own_q <= pwdata[15:0];
    end
  end

  // notice intake
  assign accept = start && !busy_q;
  assign a_id   = body_a_i[crt_pkg::ID_W-1:0];
  assign b_id   = body_b_i[crt_pkg::ID_W-1:0];
  assign own_id = own_q[crt_pkg::ID_W-1:0];

  always_comb begin
    tok_w[0]         = '0;
    tok_w[0].vld     = accept;
    tok_w[0].op      = crt_pkg::op_e'(operation_i);
    tok_w[0].act     = (a_id == own_id) || (b_id == own_id);
    tok_w[0].id      = (a_id == own_id) ? b_id : a_id;
  end

  for (genvar g = 0; g < crt_pkg::TABLE_ENTRIES; g++) begin : g_cell
    crt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok_w[g]),
      .cmt_i (cmt),
      .tok_o (tok_w[g+1])
    );
  end

  assign last = tok_w[crt_pkg::TABLE_ENTRIES];

  // outcome at the end of the row
  always_comb begin
    ev = crt_pkg::EV_NONE;
    if (last.act) begin
      if (last.op == crt_pkg::OP_BEGIN) begin
        if (!last.hit) begin
          ev = last.claimed ? crt_pkg::EV_BEGAN : crt_pkg::EV_FULL;
        end
      end else if (last.erased) begin
        ev = crt_pkg::EV_ENDED;
      end
    end
    cmt.done   = last.vld;
    cmt.commit = last.vld && (ev == crt_pkg::EV_BEGAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= last.vld;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last.vld) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.vld) begin
      ev_q  <= ev;
      pid_q <= (ev != crt_pkg::EV_NONE) ? 16'(last.id) : 16'd0;
      cnt_q <= (ev == crt_pkg::EV_BEGAN) ? 8'd1 : 8'd0;
    end
  end

  assign busy         = busy_q;
  assign res_valid_o  = res_valid_q;
  assign event_res_o  = res_valid_q ? ev_q : crt_pkg::EV_NONE;
  assign partner_id_o = res_valid_q ? pid_q : 16'd0;
  assign pair_count_o = res_valid_q ? cnt_q : 8'd0;

  `CRT_ASSERT(a_busy_after_take, clk_i, rst_ni, (start && !busy) |=> busy,
              "notice taken but block not busy")
  `CRT_ASSERT(a_result_ends_busy, clk_i, rst_ni, res_valid_o |-> (!busy && $past(busy)),
              "result without a notice in flight")
  `CRT_ASSERT(a_began_count, clk_i, rst_ni,
              (res_valid_o && (event_res_o == crt_pkg::EV_BEGAN)) |-> (pair_count_o == 8'd1),
              "new partner reported with count other than one")

endmodule

@@ test/tb_contact_refcount_table.sv @@
// self-checking testbench for contact_refcount_table: directed and random notices,
// owner id programming over apb, every result checked against an in-bench table model
// depends on crt_pkg and the contact_refcount_table rtl
`timescale 1ns / 1ps

module tb_contact_refcount_table;

  localparam logic [2:0] OWN_BODY_ID_ADDR = 3'(4 * crt_pkg::REG_OWN_BODY_ID);
  localparam int NOTICE_LATENCY = crt_pkg::TABLE_ENTRIES + 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    crt_pkg::event_e                ev;
    logic [15:0]                    partner;
    logic [crt_pkg::COUNT_BITS-1:0] count;
  } contact_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [0:0]  operation_i;
  logic [15:0] body_a_i;
  logic [15:0] body_b_i;
  logic        res_valid_o;
  logic [1:0]  event_res_o;
  logic [15:0] partner_id_o;
  logic [7:0]  pair_count_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted contents of the partner table
  logic                           tbl_valid [crt_pkg::TABLE_ENTRIES] = '{default: 1'b0};
  logic [15:0]                    tbl_partner [crt_pkg::TABLE_ENTRIES];
  logic [crt_pkg::COUNT_BITS-1:0] tbl_count [crt_pkg::TABLE_ENTRIES];
  logic [15:0]                    owner_id = 16'h0000;

  contact_result_t pending_results [$];
  contact_result_t want_res;
  int err_count = 0;
  int idle_pct = 38;
  int quiet_cycles = 0;
  logic [15:0] partner_pool [POOL_SIZE];

  contact_refcount_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .body_a_i    (body_a_i),
    .body_b_i    (body_b_i),
    .res_valid_o (res_valid_o),
    .event_res_o (event_res_o),
    .partner_id_o(partner_id_o),
    .pair_count_o(pair_count_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic contact_result_t predict_contact(crt_pkg::op_e op, logic [15:0] a,
                                                      logic [15:0] b);
    contact_result_t r;
    logic [15:0] other;
    int hit_slot;
    int free_slot;
    r.ev = crt_pkg::EV_NONE;
    r.partner = '0;
    r.count = '0;
    // owner on side a wins, so a self pair takes body_b as partner
    if (a == owner_id) other = b;
    else if (b == owner_id) other = a;
    else return r;
    hit_slot = -1;
    free_slot = -1;
    for (int i = 0; i < crt_pkg::TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_partner[i] == other && hit_slot < 0) hit_slot = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    if (op == crt_pkg::OP_BEGIN) begin
      if (hit_slot >= 0) begin
        if (tbl_count[hit_slot] != crt_pkg::CNT_MAX)
          tbl_count[hit_slot] = tbl_count[hit_slot] + 1'b1;
      end else if (free_slot >= 0) begin
        tbl_valid[free_slot] = 1'b1;
        tbl_partner[free_slot] = other;
        tbl_count[free_slot] = crt_pkg::CNT_ONE;
        r.ev = crt_pkg::EV_BEGAN;
        r.partner = other;
        r.count = crt_pkg::CNT_ONE;
      end else begin
        r.ev = crt_pkg::EV_FULL;
        r.partner = other;
      end
    end else if (hit_slot >= 0) begin
      if (tbl_count[hit_slot] > crt_pkg::CNT_ONE) begin
        tbl_count[hit_slot] = tbl_count[hit_slot] - 1'b1;
      end else begin
        tbl_valid[hit_slot] = 1'b0;
        r.ev = crt_pkg::EV_ENDED;
        r.partner = other;
      end
    end
    return r;
  endfunction

  task automatic send_notice(crt_pkg::op_e op, logic [15:0] a, logic [15:0] b);
    contact_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    operation_i <= op;
    body_a_i <= a;
    body_b_i <= b;
    do @(posedge clk_i); while (busy);
    r = predict_contact(op, a, b);
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write the owner id, then read it back
  task automatic program_owner(logic [15:0] id);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= OWN_BODY_ID_ADDR;
    pwdata <= {16'h0000, id};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    owner_id = id;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== id) begin
      $display("%0t: own_body_id readback expected %h actual %h", $time, id, prdata[15:0]);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_owner();
    send_notice(crt_pkg::OP_BEGIN, 16'h0000, 16'h0005);
    send_notice(crt_pkg::OP_END, 16'h0005, 16'h0000);
    send_notice(crt_pkg::OP_BEGIN, 16'h0001, 16'h0002);
  endtask

  task automatic test_pair_handling();
    program_owner(16'hFFFF);
    send_notice(crt_pkg::OP_BEGIN, 16'hFFFF, 16'h0000);
    send_notice(crt_pkg::OP_BEGIN, 16'h0000, 16'hFFFF);
    send_notice(crt_pkg::OP_END, 16'hFFFF, 16'h0000);
    send_notice(crt_pkg::OP_END, 16'h0000, 16'hFFFF);
    send_notice(crt_pkg::OP_END, 16'hFFFF, 16'h0007);
    send_notice(crt_pkg::OP_BEGIN, 16'hFFFF, 16'hFFFF);
    send_notice(crt_pkg::OP_END, 16'hFFFF, 16'hFFFF);
    send_notice(crt_pkg::OP_BEGIN, 16'h1234, 16'hFFFF);
    send_notice(crt_pkg::OP_END, 16'hFFFF, 16'h1234);
    send_notice(crt_pkg::OP_BEGIN, 16'h0000, 16'hFFFE);
    send_notice(crt_pkg::OP_END, 16'h5555, 16'hAAAA);
  endtask

  task automatic test_table_full();
    program_owner(16'h1234);
    for (int i = 0; i < crt_pkg::TABLE_ENTRIES; i++)
      send_notice(crt_pkg::OP_BEGIN, 16'h1234, 16'h8001 + 16'(i * 16'h0111));
    send_notice(crt_pkg::OP_BEGIN, 16'h4321, 16'h1234);
    // known partner still counts up while the table is full
    send_notice(crt_pkg::OP_BEGIN, 16'h8001, 16'h1234);
    for (int i = 0; i < crt_pkg::TABLE_ENTRIES; i++)
      send_notice(crt_pkg::OP_END, 16'h8001 + 16'(i * 16'h0111), 16'h1234);
    send_notice(crt_pkg::OP_END, 16'h1234, 16'h8001);
    send_notice(crt_pkg::OP_END, 16'h1234, 16'h4321);
  endtask

  task automatic test_count_saturation();
    program_owner(16'h8000);
    for (int i = 0; i < 258; i++) send_notice(crt_pkg::OP_BEGIN, 16'h8000, 16'h7FFF);
    for (int i = 0; i < 256; i++) send_notice(crt_pkg::OP_END, 16'h7FFF, 16'h8000);
  endtask

  task automatic test_random_contacts();
    logic [15:0] owners [4];
    logic [15:0] partner;
    int pick;
    crt_pkg::op_e op;
    owners[0] = 16'($urandom());
    owners[1] = 16'h0000;
    owners[2] = 16'hFFFF;
    owners[3] = 16'($urandom());
    partner_pool[0] = 16'h0000;
    partner_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) partner_pool[i] = 16'($urandom());
    for (int phase = 0; phase < 4; phase++) begin
      program_owner(owners[phase]);
      idle_pct = (phase == 0) ? 0 : 38;
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        op = crt_pkg::op_e'($urandom_range(99) < 52 ? crt_pkg::OP_BEGIN : crt_pkg::OP_END);
        if (pick < 8) begin
          // unrelated pairs and stray ends
          send_notice(crt_pkg::op_e'($urandom_range(1)), 16'($urandom()), 16'($urandom()));
        end else begin
          partner = (pick < 11) ? owner_id : partner_pool[$urandom_range(POOL_SIZE - 1)];
          if ($urandom_range(1)) send_notice(op, owner_id, partner);
          else send_notice(op, partner, owner_id);
        end
      end
    end
    idle_pct = 38;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer ev %0d partner %h count %0d", $time,
                 event_res_o, partner_id_o, pair_count_o);
        err_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (event_res_o !== want_res.ev) begin
          $display("%0t: event_res expected %0d actual %0d", $time, want_res.ev, event_res_o);
          err_count++;
        end
        if (partner_id_o !== want_res.partner) begin
          $display("%0t: partner_id expected %h actual %h", $time, want_res.partner,
                   partner_id_o);
          err_count++;
        end
        if (pair_count_o !== want_res.count) begin
          $display("%0t: pair_count expected %0d actual %0d", $time, want_res.count,
                   pair_count_o);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    operation_i <= crt_pkg::OP_BEGIN;
    body_a_i <= '0;
    body_b_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_owner();
    test_pair_handling();
    test_table_full();
    test_count_saturation();
    test_random_contacts();
    drain_results();
    repeat (NOTICE_LATENCY) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
